>>> rtl/potential_field_steering_top_macros.svh
// Assertion macros for the potential field steering block.
// Every macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef POTENTIAL_FIELD_STEERING_TOP_MACROS_SVH
`define POTENTIAL_FIELD_STEERING_TOP_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define PFS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("potential field steering check failed");

// The consequent must hold in the same cycle as the antecedent.
`define PFS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("potential field steering check failed");

`endif

>>> rtl/pfs_pkg.sv
// Shared types, constants and helper functions for the potential field steering block.
// No dependencies; pfs_mul, pfs_core and the top level import this package.
`default_nettype none
package pfs_pkg;

   // Width of the scan force accumulator (signed, 16 fractional bits).
   localparam int ACCUMULATOR_BITS = 32;
   // Working width of the accumulator update, wide enough for the capped force.
   localparam int MAG_W = 51;
   localparam int SUM_W = ((ACCUMULATOR_BITS > MAG_W) ? ACCUMULATOR_BITS : MAG_W) + 2;
   // Working width of the steering output sum.
   localparam int OUT_W = ((ACCUMULATOR_BITS > 32) ? ACCUMULATOR_BITS : 32) + 1;

   // Shared multiplier operand widths.
   localparam int MUL_A_W = 36;
   localparam int MUL_B_W = 32;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // Width of the base-2 log of the force magnitude.
   localparam int L_W = 44;

   localparam logic [15:0] INF_RANGE   = 16'hFFFF;
   localparam logic [16:0] PI_Q13      = 17'd25736;
   localparam logic [16:0] HALF_PI_Q13 = 17'd12868;
   localparam logic [16:0] TWO_PI_Q13  = 17'd51472;
   localparam logic [31:0] LN2_Q30     = 32'd744261118;
   localparam logic [31:0] LOG2E_Q16   = 32'd94548;
   localparam logic [31:0] ONE_Q30     = 32'd1073741824;
   localparam logic [MAG_W-1:0] MAG_CAP = MAG_W'(1) << 50;

   localparam logic signed [SUM_W-1:0] ACC_MAX_EXT =
      {{(SUM_W-ACCUMULATOR_BITS+1){1'b0}}, {(ACCUMULATOR_BITS-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] ACC_MIN_EXT = ~ACC_MAX_EXT;
   localparam logic signed [OUT_W-1:0] I32_MAX_EXT = {{(OUT_W-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [OUT_W-1:0] I32_MIN_EXT = ~I32_MAX_EXT;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      CSR_FORCE_GAIN    = 2'd0,
      CSR_INVERSE_SIGMA = 2'd1,
      CSR_ANGLE_START   = 2'd2,
      CSR_ANGLE_STEP    = 2'd3
   } csr_index_type;

   // Sequencer of the force evaluation.
   typedef enum logic [4:0] {
      C_IDLE, C_SIN_SQ, C_SIN_X2, C_SIN_DIV, C_SIN_UPD, C_SIN_OUT, C_DQ, C_DSQ,
      C_ESIG, C_LEXP_HI, C_LEXP_LO, C_LOG, C_LR_MUL, C_LR_DIV, C_EXP_Y,
      C_EXP_MUL, C_EXP_DIV, C_FINISH
   } core_state_type;

   // Transaction control of the top level.
   typedef enum logic {
      T_IDLE,
      T_BUSY
   } top_state_type;

   // Start request to the force unit.
   typedef struct packed {
      logic        start;
      logic [15:0] range;
      logic [15:0] angle;
   } core_req_type;

   // Completion status from the force unit.
   typedef struct packed {
      logic             done;
      logic [MAG_W-1:0] mag;
      logic             subtract;
   } core_rsp_type;

   // Reciprocal ceil(2^32 / d), so that floor(x / d) = (x * r) >> 32 holds exactly
   // over the operand ranges that the force unit divides.
   function automatic logic [31:0] recip_q32(input logic [5:0] divisor);
      logic [31:0] r;
      case (divisor)
         6'd2:    r = 32'd2147483648;
         6'd3:    r = 32'd1431655766;
         6'd4:    r = 32'd1073741824;
         6'd5:    r = 32'd858993460;
         6'd6:    r = 32'd715827883;
         6'd7:    r = 32'd613566757;
         6'd8:    r = 32'd536870912;
         6'd9:    r = 32'd477218589;
         6'd10:   r = 32'd429496730;
         6'd20:   r = 32'd214748365;
         6'd42:   r = 32'd102261127;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

   // Position of the leading one of a 16-bit value (zero for zero).
   function automatic logic [3:0] msb_index(input logic [15:0] v);
      logic [3:0] k;
      k = 4'd0;
      for (int i = 0; i < 16; i++) begin
         if (v[i]) begin
            k = 4'(i);
         end
      end
      return k;
   endfunction

   // Mantissa normalized to Q30, leading one at bit 30.
   function automatic logic [30:0] log_norm(input logic [15:0] v);
      logic [3:0] k;
      k = msb_index(v);
      return {15'd0, v} << (5'd30 - {1'b0, k});
   endfunction

endpackage
`default_nettype wire

>>> rtl/pfs_mul.sv
// Shared unsigned multiplier of the force unit with a registered product.
// Depends on pfs_pkg for the operand widths.
`default_nettype none
module pfs_mul (
   input  wire logic                         clock,
   input  wire logic [pfs_pkg::MUL_A_W-1:0] mul_a,
   input  wire logic [pfs_pkg::MUL_B_W-1:0] mul_b,
   output logic      [pfs_pkg::PROD_W-1:0]  prod_ff
);
   import pfs_pkg::*;

   logic [PROD_W-1:0] prod_in;

   // One product per cycle, available in the following cycle.
   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule
`default_nettype wire

>>> rtl/pfs_core.sv
// Force unit: a sequencer that evaluates one beam's repulsion magnitude on the shared
// multiplier (sine series, log2 by squaring, exp2 series). Depends on pfs_pkg, pfs_mul.
`default_nettype none
module pfs_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pfs_pkg::core_req_type req,
   input  wire logic [15:0]          force_gain,
   input  wire logic [15:0]          inverse_sigma,
   output pfs_pkg::core_rsp_type     rsp
);
   import pfs_pkg::*;

   core_state_type state_ff, state_in;

   logic [3:0]            cnt_ff, cnt_in;
   logic                  sel_ff, sel_in;
   logic [13:0]           m_ff, m_in;
   logic                  neg_ff, neg_in;
   logic [15:0]           r_ff, r_in;
   logic [14:0]           x2_ff, x2_in;
   logic                  pos_ff, pos_in;
   logic [15:0]           el_ff, el_in;
   logic [41:0]           lexp_ff, lexp_in;
   logic [19:0]           ly_ff, ly_in;
   logic signed [20:0]    lg_ff, lg_in;
   logic                  lrneg_ff, lrneg_in;
   logic signed [L_W-1:0] l_ff, l_in;
   logic [29:0]           y_ff, y_in;
   logic [31:0]           esum_ff, esum_in;
   logic [MAG_W-1:0]      mag_ff, mag_in;
   logic                  done_ff, done_in;

   logic [MUL_A_W-1:0]    mul_a;
   logic [MUL_B_W-1:0]    mul_b;
   logic [PROD_W-1:0]     prod;

   pfs_mul u_mul (
      .clock  (clock),
      .mul_a  (mul_a),
      .mul_b  (mul_b),
      .prod_ff(prod)
   );

   // Fold the beam angle into [-pi/2, pi/2] and keep its magnitude.
   logic [16:0] fold_abs, fold_a, fold_b;
   logic        fold_wrap;
   assign fold_abs  = req.angle[15] ? (17'h10000 - {1'b0, req.angle}) : {1'b0, req.angle};
   assign fold_wrap = fold_abs > PI_Q13;
   assign fold_a    = fold_wrap ? (TWO_PI_Q13 - fold_abs) : fold_abs;
   assign fold_b    = (fold_a > HALF_PI_Q13) ? (PI_Q13 - fold_a) : fold_a;

   // Rounding of the sine series steps and of the lateral distance.
   logic [28:0] x2_sum, s_sum;
   logic [31:0] dq_sum;
   logic [15:0] sin_mag;
   logic [17:0] dq;
   logic [14:0] sin_p;
   logic [39:0] e16;
   assign x2_sum  = 29'(prod[27:0]) + 29'd4096;
   assign s_sum   = 29'(prod[27:0]) + 29'd4096;
   assign sin_mag = s_sum[28:13];
   assign dq_sum  = {1'b0, prod[30:0]} + 32'd8192;
   assign dq      = {4'd0, dq_sum[31:18]} << 4 | 18'(dq_sum[17:14]);
   assign sin_p   = 15'(17'd16384 - {1'b0, prod[47:32]});
   assign e16     = prod[51:12];

   // Divisors of the sine series steps.
   logic [5:0] sin_div;
   always_comb begin
      case (cnt_ff)
         4'd0:    sin_div = 6'd42;
         4'd1:    sin_div = 6'd20;
         default: sin_div = 6'd6;
      endcase
   end

   // One fraction bit of log2 per squaring.
   logic [31:0]        log_mm;
   logic               log_bit;
   logic [30:0]        log_mn;
   logic [19:0]        log_ly;
   logic signed [20:0] log_val;
   logic [19:0]        log_abs;
   assign log_mm  = prod[61:30];
   assign log_bit = log_mm[31];
   assign log_mn  = log_bit ? log_mm[31:1] : log_mm[30:0];
   assign log_ly  = ly_ff | (20'(log_bit) << cnt_ff);
   assign log_val = $signed({1'b0, log_ly}) - 21'sd524288;
   assign log_abs = log_val[20] ? 20'(-log_val) : 20'(log_val);

   // Log2 of the force in Q16.
   logic signed [L_W-1:0] lr_s, l_calc;
   assign lr_s   = lrneg_ff ? -$signed({(L_W-20)'(0), prod[51:32]})
                            : $signed({(L_W-20)'(0), prod[51:32]});
   assign l_calc = L_W'(lg_ff) - lr_s - $signed({2'b00, lexp_ff}) + L_W'(1 << 20);

   // Scale the exp2 mantissa by the integer part of the log.
   logic [L_W-17:0]  fin_n;
   logic [5:0]       fin_n6;
   logic [MAG_W-1:0] fin_shift;
   assign fin_n     = l_ff[L_W-1:16];
   assign fin_n6    = fin_n[5:0];
   assign fin_shift = (fin_n6 >= 6'd30) ? ({19'd0, esum_ff} << 5'(fin_n6 - 6'd30))
                                        : MAG_W'(esum_ff >> 5'(6'd30 - fin_n6));

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         C_IDLE:    if (req.start) state_in = C_SIN_SQ;
         C_SIN_SQ:  state_in = C_SIN_X2;
         C_SIN_X2:  state_in = C_SIN_DIV;
         C_SIN_DIV: state_in = C_SIN_UPD;
         C_SIN_UPD: state_in = (cnt_ff == 4'd2) ? C_SIN_OUT : C_SIN_DIV;
         C_SIN_OUT: state_in = C_DQ;
         C_DQ:      state_in = C_DSQ;
         C_DSQ:     state_in = C_ESIG;
         C_ESIG:    state_in = C_LEXP_HI;
         C_LEXP_HI: state_in = C_LEXP_LO;
         C_LEXP_LO: state_in = C_LOG;
         C_LOG:     if (cnt_ff == 4'd0 && sel_ff) state_in = C_LR_MUL;
         C_LR_MUL:  state_in = C_LR_DIV;
         C_LR_DIV:  state_in = C_EXP_Y;
         C_EXP_Y:   state_in = C_EXP_MUL;
         C_EXP_MUL: state_in = C_EXP_DIV;
         C_EXP_DIV: state_in = (cnt_ff == 4'd10) ? C_FINISH : C_EXP_MUL;
         C_FINISH:  state_in = C_IDLE;
         default:   state_in = C_IDLE;
      endcase
   end

   // Datapath updates and multiplier operands of each step.
   always_comb begin
      cnt_in   = cnt_ff;
      sel_in   = sel_ff;
      m_in     = m_ff;
      neg_in   = neg_ff;
      r_in     = r_ff;
      x2_in    = x2_ff;
      pos_in   = pos_ff;
      el_in    = el_ff;
      lexp_in  = lexp_ff;
      ly_in    = ly_ff;
      lg_in    = lg_ff;
      lrneg_in = lrneg_ff;
      l_in     = l_ff;
      y_in     = y_ff;
      esum_in  = esum_ff;
      mag_in   = mag_ff;
      done_in  = 1'b0;
      mul_a    = '0;
      mul_b    = '0;
      unique case (state_ff)
         C_IDLE: begin
            if (req.start) begin
               m_in   = fold_b[13:0];
               neg_in = req.angle[15] ^ fold_wrap;
               r_in   = req.range;
            end
         end
         C_SIN_SQ: begin
            mul_a = MUL_A_W'(m_ff);
            mul_b = MUL_B_W'(m_ff);
         end
         C_SIN_X2: begin
            x2_in  = x2_sum[27:13];
            cnt_in = 4'd0;
            mul_a  = MUL_A_W'(x2_sum[27:13]);
            mul_b  = 32'd16384;
         end
         C_SIN_DIV: begin
            mul_a = MUL_A_W'(prod[28:13]);
            mul_b = recip_q32(sin_div);
         end
         C_SIN_UPD: begin
            mul_b = MUL_B_W'(sin_p);
            if (cnt_ff == 4'd2) begin
               mul_a = MUL_A_W'(m_ff);
            end else begin
               mul_a  = MUL_A_W'(x2_ff);
               cnt_in = cnt_ff + 4'd1;
            end
         end
         C_SIN_OUT: begin
            pos_in = !neg_ff && (sin_mag != 16'd0);
            mul_a  = MUL_A_W'(r_ff);
            mul_b  = MUL_B_W'(sin_mag);
         end
         C_DQ: begin
            mul_a = MUL_A_W'(dq);
            mul_b = MUL_B_W'(dq);
         end
         C_DSQ: begin
            mul_a = prod[35:0];
            mul_b = MUL_B_W'(inverse_sigma);
         end
         C_ESIG: begin
            el_in = e16[15:0];
            mul_a = MUL_A_W'(e16[39:16]);
            mul_b = LOG2E_Q16;
         end
         C_LEXP_HI: begin
            lexp_in = 42'(prod[40:0]);
            mul_a   = MUL_A_W'(el_ff);
            mul_b   = LOG2E_Q16;
         end
         C_LEXP_LO: begin
            lexp_in = lexp_ff + 42'(prod[32:16]);
            ly_in   = {msb_index(force_gain), 16'd0};
            cnt_in  = 4'd15;
            sel_in  = 1'b0;
            mul_a   = MUL_A_W'(log_norm(force_gain));
            mul_b   = MUL_B_W'(log_norm(force_gain));
         end
         C_LOG: begin
            ly_in = log_ly;
            if (cnt_ff != 4'd0) begin
               cnt_in = cnt_ff - 4'd1;
               mul_a  = MUL_A_W'(log_mn);
               mul_b  = MUL_B_W'(log_mn);
            end else if (!sel_ff) begin
               // Gain done; start the log of the range.
               lg_in  = log_val;
               sel_in = 1'b1;
               ly_in  = {msb_index(r_ff), 16'd0};
               cnt_in = 4'd15;
               mul_a  = MUL_A_W'(log_norm(r_ff));
               mul_b  = MUL_B_W'(log_norm(r_ff));
            end else begin
               lrneg_in = log_val[20];
               mul_a    = MUL_A_W'(log_abs);
               mul_b    = 32'd11;
            end
         end
         C_LR_MUL: begin
            mul_a = MUL_A_W'(prod[23:0]);
            mul_b = recip_q32(6'd10);
         end
         C_LR_DIV: begin
            l_in  = l_calc;
            mul_a = MUL_A_W'(l_calc[15:0]);
            mul_b = LN2_Q30;
         end
         C_EXP_Y: begin
            // The first series term equals y.
            y_in    = prod[45:16];
            esum_in = ONE_Q30 + 32'(prod[45:16]);
            cnt_in  = 4'd2;
            mul_a   = MUL_A_W'(prod[45:16]);
            mul_b   = MUL_B_W'(prod[45:16]);
         end
         C_EXP_MUL: begin
            mul_a = MUL_A_W'(prod[59:30]);
            mul_b = recip_q32(6'(cnt_ff));
         end
         C_EXP_DIV: begin
            esum_in = esum_ff + 32'(prod[61:32]);
            if (cnt_ff != 4'd10) begin
               cnt_in = cnt_ff + 4'd1;
               mul_a  = MUL_A_W'(prod[61:32]);
               mul_b  = MUL_B_W'(y_ff);
            end
         end
         C_FINISH: begin
            done_in = 1'b1;
            if (force_gain == 16'd0) begin
               mag_in = '0;
            end else if (r_ff == 16'd0) begin
               mag_in = MAG_CAP;
            end else if (l_ff[L_W-1]) begin
               mag_in = '0;
            end else if (fin_n >= (L_W-16)'(50)) begin
               mag_in = MAG_CAP;
            end else begin
               mag_in = fin_shift;
            end
         end
         default: begin
            done_in = 1'b0;
         end
      endcase
   end

   // Sequencer control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      sel_ff   <= sel_in;
      m_ff     <= m_in;
      neg_ff   <= neg_in;
      r_ff     <= r_in;
      x2_ff    <= x2_in;
      pos_ff   <= pos_in;
      el_ff    <= el_in;
      lexp_ff  <= lexp_in;
      ly_ff    <= ly_in;
      lg_ff    <= lg_in;
      lrneg_ff <= lrneg_in;
      l_ff     <= l_in;
      y_ff     <= y_in;
      esum_ff  <= esum_in;
      mag_ff   <= mag_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.mag      = mag_ff;
   assign rsp.subtract = pos_ff && (r_ff != 16'd0);

endmodule
`default_nettype wire

>>> rtl/potential_field_steering_top.sv
// Potential field steering: a finite beam runs through the force unit sequencer around one
// shared multiplier, including the two log2 evaluations; req_ready is low meanwhile.
// An infinite beam completes on acceptance; a desired vector's result is in the output
// register the cycle after acceptance. Synchronous active-high reset restores the register
// defaults, clears both force sums and flags and restarts the beam angle at angle_start.
`default_nettype none
module potential_field_steering_top (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_kind,
   input  wire logic [15:0]           req_range,
   input  wire logic                  req_last_beam,
   input  wire logic signed [31:0]    req_desired_x,
   input  wire logic signed [31:0]    req_desired_y,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic signed [31:0]         rsp_trajectory_x,
   output logic signed [31:0]         rsp_trajectory_y,
   output logic                       rsp_force_saturated,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire pfs_pkg::csr_index_type csr_index,
   input  wire logic [15:0]           csr_data
);
   import pfs_pkg::*;

   top_state_type state_ff, state_in;

   logic [15:0]                        gain_ff, gain_in;
   logic [15:0]                        isig_ff, isig_in;
   logic [15:0]                        astart_ff, astart_in;
   logic [15:0]                        astep_ff, astep_in;
   logic [15:0]                        angle_ff, angle_in;
   logic signed [ACCUMULATOR_BITS-1:0] sum_ff, sum_in;
   logic signed [ACCUMULATOR_BITS-1:0] lsum_ff, lsum_in;
   logic                               ovf_ff, ovf_in;
   logic                               lovf_ff, lovf_in;
   logic                               last_ff, last_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]                 rsp_x_ff, rsp_x_in;
   logic signed [31:0]                 rsp_y_ff, rsp_y_in;
   logic                               rsp_sat_ff, rsp_sat_in;

   core_req_type core_req;
   core_rsp_type core_rsp;

   logic accept, beam_inf, beam_fin, fin_last;

   pfs_core u_core (
      .clock        (clock),
      .reset        (reset),
      .req          (core_req),
      .force_gain   (gain_ff),
      .inverse_sigma(isig_ff),
      .rsp          (core_rsp)
   );

   // Input transaction and force unit start.
   assign accept         = req_valid && req_ready;
   assign beam_inf       = accept && !req_kind && (req_range == INF_RANGE);
   assign core_req.start = accept && !req_kind && (req_range != INF_RANGE);
   assign core_req.range = req_range;
   assign core_req.angle = angle_ff;

   // A beam finishes at once when infinite, otherwise when the force unit is done.
   assign beam_fin = beam_inf || core_rsp.done;
   assign fin_last = beam_inf ? req_last_beam : last_ff;

   // Saturating accumulation of the signed force term.
   logic signed [SUM_W-1:0] acc_ext, mag_ext, acc_t;
   logic                    acc_hi, acc_lo;
   logic signed [ACCUMULATOR_BITS-1:0] acc_sat;
   assign acc_ext = SUM_W'(sum_ff);
   assign mag_ext = $signed({{(SUM_W-MAG_W){1'b0}}, core_rsp.mag});
   assign acc_t   = core_rsp.subtract ? (acc_ext - mag_ext) : (acc_ext + mag_ext);
   assign acc_hi  = acc_t > ACC_MAX_EXT;
   assign acc_lo  = acc_t < ACC_MIN_EXT;
   assign acc_sat = acc_hi ? ACC_MAX_EXT[ACCUMULATOR_BITS-1:0]
                  : acc_lo ? ACC_MIN_EXT[ACCUMULATOR_BITS-1:0]
                  : acc_t[ACCUMULATOR_BITS-1:0];

   // Steering output: desired y plus the latched force, saturated to 32 bits.
   logic signed [OUT_W-1:0] out_t;
   logic signed [31:0]      out_y;
   assign out_t = OUT_W'(req_desired_y) + OUT_W'(lsum_ff);
   assign out_y = (out_t > I32_MAX_EXT) ? 32'sh7FFFFFFF
                : (out_t < I32_MIN_EXT) ? 32'sh80000000
                : out_t[31:0];

   // Next state of the transaction control.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE:  if (core_req.start) state_in = T_BUSY;
         T_BUSY:  if (core_rsp.done) state_in = T_IDLE;
         default: state_in = T_IDLE;
      endcase
   end

   // Handshake outputs of the transaction control.
   always_comb begin
      unique case (state_ff)
         T_IDLE:  req_ready = !rsp_valid_ff || rsp_ready;
         T_BUSY:  req_ready = 1'b0;
         default: req_ready = 1'b0;
      endcase
   end

   // Configuration register writes.
   always_comb begin
      gain_in   = gain_ff;
      isig_in   = isig_ff;
      astart_in = astart_ff;
      astep_in  = astep_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FORCE_GAIN:    gain_in   = csr_data;
            CSR_INVERSE_SIGMA: isig_in   = csr_data;
            CSR_ANGLE_START:   astart_in = csr_data;
            CSR_ANGLE_STEP:    astep_in  = csr_data;
            default:           gain_in   = gain_ff;
         endcase
      end
   end

   // Scan state: sums, flags and the running beam angle.
   always_comb begin
      sum_in   = sum_ff;
      ovf_in   = ovf_ff;
      lsum_in  = lsum_ff;
      lovf_in  = lovf_ff;
      angle_in = angle_ff;
      last_in  = last_ff;
      if (core_req.start) begin
         last_in = req_last_beam;
      end
      if (beam_fin) begin
         if (core_rsp.done) begin
            sum_in = acc_sat;
            ovf_in = ovf_ff || acc_hi || acc_lo;
         end
         angle_in = angle_ff + astep_ff;
         if (fin_last) begin
            lsum_in  = sum_in;
            lovf_in  = ovf_in;
            sum_in   = '0;
            ovf_in   = 1'b0;
            angle_in = astart_ff;
         end
      end
   end

   // Output register: a new result replaces the taken one.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_sat_in   = rsp_sat_ff;
      if (accept && req_kind) begin
         rsp_valid_in = 1'b1;
         rsp_sat_in   = lovf_ff;
         if (req_desired_x == 32'sd0 && req_desired_y == 32'sd0) begin
            rsp_x_in = 32'sd0;
            rsp_y_in = 32'sd0;
         end else begin
            rsp_x_in = req_desired_x;
            rsp_y_in = out_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         gain_ff      <= 16'd11520;
         isig_ff      <= 16'd3413;
         astart_ff    <= 16'hCDBC;
         astep_ff     <= 16'd143;
         angle_ff     <= 16'hCDBC;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         lsum_ff      <= '0;
         lovf_ff      <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         isig_ff      <= isig_in;
         astart_ff    <= astart_in;
         astep_ff     <= astep_in;
         angle_ff     <= angle_in;
         sum_ff       <= sum_in;
         ovf_ff       <= ovf_in;
         lsum_ff      <= lsum_in;
         lovf_ff      <= lovf_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_trajectory_x    = rsp_x_ff;
   assign rsp_trajectory_y    = rsp_y_ff;
   assign rsp_force_saturated = rsp_sat_ff;

endmodule
`default_nettype wire

>>> rtl/pfs_checker.sv
// Port-level checks of the potential field steering top level, attached by bind.
// Depends on potential_field_steering_top_macros.svh.
`default_nettype none
`include "potential_field_steering_top_macros.svh"
module pfs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_kind,
   input wire logic [31:0] req_desired_x,
   input wire logic [31:0] req_desired_y,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_trajectory_x,
   input wire logic [31:0] rsp_trajectory_y
);

   // A stalled result holds.
   `PFS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_trajectory_y))

   // No new transaction while an untaken result fills the output register.
   `PFS_ASSERT_NOW(a_full_stall, rsp_valid && !rsp_ready, !req_ready)

   // A beam never produces a result.
   `PFS_ASSERT_NEXT(a_beam_silent, req_valid && req_ready && !req_kind && !rsp_valid, !rsp_valid)

   // A zero desired vector gives a zero command.
   `PFS_ASSERT_NEXT(a_zero_vec, req_valid && req_ready && req_kind && req_desired_x == 32'd0 && req_desired_y == 32'd0, rsp_valid && rsp_trajectory_x == 32'd0 && rsp_trajectory_y == 32'd0)

   // The x command passes through unchanged.
   `PFS_ASSERT_NEXT(a_x_pass, req_valid && req_ready && req_kind, rsp_valid && (rsp_trajectory_x == $past(req_desired_x) || rsp_trajectory_x == 32'd0))

endmodule

bind potential_field_steering_top pfs_checker u_pfs_checker (.*);
`default_nettype wire
